>>> sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the segment-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned LANES      = 4;   // endpoint-to-segment distances
  localparam int unsigned DIV_STEPS  = 16;  // fraction bits of t
  localparam int unsigned SQRT_STEPS = 19;  // root bits over the radicand
  localparam int unsigned RAD_W      = 2 * SQRT_STEPS;

  typedef struct packed {
    logic signed [15:0] a_start_x;
    logic signed [15:0] a_start_y;
    logic signed [15:0] a_end_x;
    logic signed [15:0] a_end_y;
    logic signed [15:0] b_start_x;
    logic signed [15:0] b_start_y;
    logic signed [15:0] b_end_x;
    logic signed [15:0] b_end_y;
  } in_req_t;

  typedef struct packed {
    logic [16:0] gap_length;
    logic        crossing;
  } out_rsp_t;

  // segment direction and point offset from the segment start
  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] ex;
    logic signed [16:0] ey;
  } geo_t;

  typedef struct packed {
    geo_t        geo;
    logic        one;   // t clamps to 1
    logic [32:0] rem;
    logic [32:0] l2;
    logic [15:0] q;
  } div_lane_t;

  typedef struct packed {
    logic                        hit;
    div_lane_t [LANES-1:0]       lane;
  } div_bus_t;

  typedef struct packed {
    logic             hit;
    logic [RAD_W-1:0] rad;
  } sq_bus_t;

endpackage

>>> sv/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Differences, products, cross-product sign test and t clamping, four stages.
// ----------------------------------------------------------------------------
module ssd_front
  import ssd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_req_t  req_i,
  output logic     valid_o,
  output div_bus_t bus_o
);

  logic [3:0] vld_q;

  geo_t               geo1_q [LANES];
  geo_t               geo2_q [LANES];
  geo_t               geo3_q [LANES];
  logic signed [33:0] pxx_q [LANES];
  logic signed [33:0] pyy_q [LANES];
  logic signed [33:0] pdx_q [LANES];
  logic signed [33:0] pdy_q [LANES];
  logic signed [33:0] pc1_q [LANES];
  logic signed [33:0] pc2_q [LANES];
  logic [32:0]        l2_q  [LANES];
  logic signed [34:0] dot_q [LANES];
  logic signed [34:0] crs_q [LANES];
  div_bus_t           bus_q;

  geo_t     geo_d [LANES];
  div_bus_t bus_d;

  function automatic geo_t mk_geo(logic signed [15:0] px, logic signed [15:0] py,
                                  logic signed [15:0] x1, logic signed [15:0] y1,
                                  logic signed [15:0] x2, logic signed [15:0] y2);
    geo_t g;
    g.dx = 17'(x2) - 17'(x1);
    g.dy = 17'(y2) - 17'(y1);
    g.ex = 17'(px) - 17'(x1);
    g.ey = 17'(py) - 17'(y1);
    return g;
  endfunction

  function automatic logic straddles(logic signed [34:0] a, logic signed [34:0] b);
    logic a_pos, b_pos;
    a_pos = !a[34] && (a != '0);
    b_pos = !b[34] && (b != '0);
    return !((a_pos && b_pos) || (a[34] && b[34]));
  endfunction

  always_comb begin
    geo_d[0] = mk_geo(req_i.a_start_x, req_i.a_start_y, req_i.b_start_x, req_i.b_start_y,
                      req_i.b_end_x, req_i.b_end_y);
    geo_d[1] = mk_geo(req_i.a_end_x, req_i.a_end_y, req_i.b_start_x, req_i.b_start_y,
                      req_i.b_end_x, req_i.b_end_y);
    geo_d[2] = mk_geo(req_i.b_start_x, req_i.b_start_y, req_i.a_start_x, req_i.a_start_y,
                      req_i.a_end_x, req_i.a_end_y);
    geo_d[3] = mk_geo(req_i.b_end_x, req_i.b_end_y, req_i.a_start_x, req_i.a_start_y,
                      req_i.a_end_x, req_i.a_end_y);
  end

  // clamp t: zero when behind the start or segment has no length, one at or past the end; also the crossing flag
  always_comb begin
    logic deg_a, deg_b, dot_pos, past_end;
    deg_b = (geo3_q[0].dx == '0) && (geo3_q[0].dy == '0);
    deg_a = (geo3_q[2].dx == '0) && (geo3_q[2].dy == '0);
    bus_d.hit = !deg_a && !deg_b && straddles(crs_q[0], crs_q[1]) &&
                straddles(crs_q[2], crs_q[3]);
    for (int l = 0; l < LANES; l++) begin
      dot_pos  = !dot_q[l][34] && (dot_q[l] != '0);
      past_end = dot_q[l] >= $signed({2'b00, l2_q[l]});
      bus_d.lane[l].geo = geo3_q[l];
      bus_d.lane[l].l2  = l2_q[l];
      bus_d.lane[l].q   = '0;
      bus_d.lane[l].one = dot_pos && past_end;
      bus_d.lane[l].rem = (dot_pos && !past_end) ? dot_q[l][32:0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        geo1_q[l] <= geo_d[l];
        pxx_q[l]  <= 34'(geo1_q[l].dx) * 34'(geo1_q[l].dx);
        pyy_q[l]  <= 34'(geo1_q[l].dy) * 34'(geo1_q[l].dy);
        pdx_q[l]  <= 34'(geo1_q[l].ex) * 34'(geo1_q[l].dx);
        pdy_q[l]  <= 34'(geo1_q[l].ey) * 34'(geo1_q[l].dy);
        pc1_q[l]  <= 34'(geo1_q[l].dx) * 34'(geo1_q[l].ey);
        pc2_q[l]  <= 34'(geo1_q[l].dy) * 34'(geo1_q[l].ex);
        geo2_q[l] <= geo1_q[l];
        l2_q[l]   <= {1'b0, pxx_q[l][31:0]} + {1'b0, pyy_q[l][31:0]};
        dot_q[l]  <= 35'(pdx_q[l]) + 35'(pdy_q[l]);
        crs_q[l]  <= 35'(pc1_q[l]) - 35'(pc2_q[l]);
        geo3_q[l] <= geo2_q[l];
      end
      bus_q <= bus_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign bus_o   = bus_q;

endmodule

>>> sv/ssd_div.sv
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined restoring divider: t = dot * 2^16 / l2, one quotient bit a stage.
// ----------------------------------------------------------------------------
module ssd_div
  import ssd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_bus_t bus_i,
  output logic     valid_o,
  output div_bus_t bus_o
);

  logic [DIV_STEPS-1:0] vld_q;
  div_bus_t             st_q [DIV_STEPS];
  div_bus_t             st_d [DIV_STEPS];

  function automatic div_lane_t div_step(div_lane_t s);
    div_lane_t   n;
    logic [33:0] r2;
    logic        ge;
    n  = s;
    r2 = {s.rem, 1'b0};
    ge = r2 >= {1'b0, s.l2};
    n.rem = ge ? 33'(r2 - {1'b0, s.l2}) : r2[32:0];
    n.q   = {s.q[14:0], ge};
    return n;
  endfunction

  always_comb begin
    div_bus_t src;
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        src = bus_i;
      end else begin
        src = st_q[s-1];
      end
      st_d[s].hit = src.hit;
      for (int l = 0; l < LANES; l++) begin
        st_d[s].lane[l] = div_step(src.lane[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STEPS-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign bus_o   = st_q[DIV_STEPS-1];

endmodule

>>> sv/ssd_dist.sv
// ----------------------------------------------------------------------------
// ssd_dist
// Projection, squared distances and four-way minimum, six stages.
// ----------------------------------------------------------------------------
module ssd_dist
  import ssd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_bus_t bus_i,
  output logic     valid_o,
  output sq_bus_t  bus_o
);

  logic [5:0]         vld_q;
  logic [5:0]         hit_q;
  logic signed [34:0] prx_q [LANES];
  logic signed [34:0] pry_q [LANES];
  logic signed [16:0] ex_q  [LANES];
  logic signed [16:0] ey_q  [LANES];
  logic signed [17:0] vx_q  [LANES];
  logic signed [17:0] vy_q  [LANES];
  logic [35:0]        sqx_q [LANES];
  logic [35:0]        sqy_q [LANES];
  logic [36:0]        sum_q [LANES];
  logic [36:0]        m01_q;
  logic [36:0]        m23_q;
  logic [RAD_W-1:0]   rad_q;

  logic signed [17:0] t_s   [LANES];
  logic signed [16:0] offx  [LANES];
  logic signed [16:0] offy  [LANES];
  logic signed [35:0] sqx_s [LANES];
  logic signed [35:0] sqy_s [LANES];

  // t * d back to Q9.8, truncated toward zero
  function automatic logic signed [16:0] scale_down(logic signed [34:0] p);
    logic signed [34:0] adj;
    adj = p + (p[34] ? 35'sd65535 : 35'sd0);
    return adj[32:16];
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      t_s[l]   = bus_i.lane[l].one ? 18'sd65536 : $signed({2'b00, bus_i.lane[l].q});
      offx[l]  = scale_down(prx_q[l]);
      offy[l]  = scale_down(pry_q[l]);
      sqx_s[l] = 36'(vx_q[l]) * 36'(vx_q[l]);
      sqy_s[l] = 36'(vy_q[l]) * 36'(vy_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        prx_q[l] <= 35'(t_s[l]) * 35'(bus_i.lane[l].geo.dx);
        pry_q[l] <= 35'(t_s[l]) * 35'(bus_i.lane[l].geo.dy);
        ex_q[l]  <= bus_i.lane[l].geo.ex;
        ey_q[l]  <= bus_i.lane[l].geo.ey;
        vx_q[l]  <= 18'(ex_q[l]) - 18'(offx[l]);
        vy_q[l]  <= 18'(ey_q[l]) - 18'(offy[l]);
        sqx_q[l] <= sqx_s[l];
        sqy_q[l] <= sqy_s[l];
        sum_q[l] <= {1'b0, sqx_q[l]} + {1'b0, sqy_q[l]};
      end
      m01_q <= (sum_q[1] < sum_q[0]) ? sum_q[1] : sum_q[0];
      m23_q <= (sum_q[3] < sum_q[2]) ? sum_q[3] : sum_q[2];
      if (hit_q[4]) begin
        rad_q <= '0;
      end else begin
        rad_q <= RAD_W'((m23_q < m01_q) ? m23_q : m01_q);
      end
      hit_q <= {hit_q[4:0], bus_i.hit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o   = vld_q[5];
  assign bus_o.hit = hit_q[5];
  assign bus_o.rad = rad_q;

endmodule

>>> sv/ssd_sqrt.sv
// ----------------------------------------------------------------------------
// ssd_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ssd_sqrt
  import ssd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  sq_bus_t  bus_i,
  output logic     valid_o,
  output out_rsp_t rsp_o
);

  typedef struct packed {
    logic                  hit;
    logic [RAD_W-1:0]      rad;
    logic [SQRT_STEPS+2:0] rem;
    logic [SQRT_STEPS-1:0] root;
  } sqrt_st_t;

  logic [SQRT_STEPS-1:0] vld_q;
  sqrt_st_t              st_q [SQRT_STEPS];
  sqrt_st_t              st_d [SQRT_STEPS];

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t              n;
    logic [SQRT_STEPS+2:0] sh;
    logic [SQRT_STEPS+2:0] trial;
    logic                  ge;
    n      = s;
    sh     = {s.rem[SQRT_STEPS:0], s.rad[RAD_W-1 -: 2]};
    trial  = {1'b0, s.root, 2'b01};
    ge     = sh >= trial;
    n.rem  = ge ? sh - trial : sh;
    n.root = {s.root[SQRT_STEPS-2:0], ge};
    n.rad  = {s.rad[RAD_W-3:0], 2'b00};
    return n;
  endfunction

  always_comb begin
    sqrt_st_t src;
    for (int s = 0; s < SQRT_STEPS; s++) begin
      if (s == 0) begin
        src.hit  = bus_i.hit;
        src.rad  = bus_i.rad;
        src.rem  = '0;
        src.root = '0;
      end else begin
        src = st_q[s-1];
      end
      st_d[s] = sqrt_step(src);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQRT_STEPS; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SQRT_STEPS-2:0], valid_i};
    end
  end

  assign valid_o          = vld_q[SQRT_STEPS-1];
  assign rsp_o.gap_length = st_q[SQRT_STEPS-1].root[16:0];
  assign rsp_o.crossing   = st_q[SQRT_STEPS-1].hit;

endmodule

>>> sv/segment_segment_distance_core.sv
// ----------------------------------------------------------------------------
// segment_segment_distance_core
// Shortest distance between two 2D segments with signed Q8.8 endpoints.
// ----------------------------------------------------------------------------
// One request per cycle is taken while the output side does not stall, and
// each gives one result: 4 stages of differences, products and the
// cross-product sign test, 16 stages of the divider that forms the clamped
// projection parameter t (one quotient bit per stage), 6 stages of
// projection, squaring and the four-way minimum, 19 stages of the square
// root (one root bit per stage) and the output register. The whole pipe
// advances together; when the result register is full and not taken, all
// stages hold.
module segment_segment_distance_core
  import ssd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  in_req_t  req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output out_rsp_t rsp_o
);

  logic     en;
  logic     fr_valid, dv_valid, ds_valid, sq_valid;
  div_bus_t fr_bus, dv_bus;
  sq_bus_t  ds_bus;
  out_rsp_t sq_rsp;
  logic     rsp_valid_q;
  out_rsp_t rsp_q;

  assign en          = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = en;

  ssd_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req_valid_i), .req_i,
    .valid_o(fr_valid), .bus_o(fr_bus)
  );

  ssd_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_valid), .bus_i(fr_bus),
    .valid_o(dv_valid), .bus_o(dv_bus)
  );

  ssd_dist u_dist (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_valid), .bus_i(dv_bus),
    .valid_o(ds_valid), .bus_o(ds_bus)
  );

  ssd_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(ds_valid), .bus_i(ds_bus),
    .valid_o(sq_valid), .rsp_o(sq_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      rsp_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= sq_rsp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the segment distance pipeline against a bit-exact predictor of the
// sign test, clamped projections and floor root, with random valid and ready.
// ----------------------------------------------------------------------------
module tb_top;
  import ssd_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     req_valid_i = 1'b0;
  logic     req_ready_o;
  in_req_t  req_i = '0;
  logic     rsp_valid_o;
  logic     rsp_ready_i = 1'b0;
  out_rsp_t rsp_o;

  in_req_t  pending_q[$];
  out_rsp_t expected_q[$];
  int       mismatches = 0;
  bit       stim_done = 1'b0;
  bit       calm = 1'b0;
  int       hold_off = 0;
  int       hold_cnt = 0;

  segment_segment_distance_core i_dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint cross_of(longint x1, longint y1, longint x2, longint y2,
                                      longint px, longint py);
    return (x2 - x1) * (py - y1) - (y2 - y1) * (px - x1);
  endfunction

  function automatic bit straddles(longint a, longint b);
    return (a >= 0 && b <= 0) || (a <= 0 && b >= 0);
  endfunction

  function automatic longint point_seg_sq(longint px, longint py, longint x1, longint y1,
                                          longint x2, longint y2);
    longint dx, dy, l2, ex, ey, dot, t, ox, oy;
    dx = x2 - x1; dy = y2 - y1;
    ex = px - x1; ey = py - y1;
    l2 = dx * dx + dy * dy;
    if (l2 == 0) return ex * ex + ey * ey;
    dot = ex * dx + ey * dy;
    if (dot <= 0) t = 0;
    else if (dot >= l2) t = 65536;
    else t = (dot * 65536) / l2;
    ox = x1 + (t * dx) / 65536;  // signed division truncates toward zero
    oy = y1 + (t * dy) / 65536;
    return (px - ox) * (px - ox) + (py - oy) * (py - oy);
  endfunction

  function automatic longint floor_root(longint v);
    longint r = 0;
    for (int b = 18; b >= 0; b--) begin
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r += (64'sd1 << b);
    end
    return r;
  endfunction

  function automatic out_rsp_t predict_gap(in_req_t q);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, best, d;
    out_rsp_t r;
    bit hit = 1'b0;
    ax1 = q.a_start_x; ay1 = q.a_start_y; ax2 = q.a_end_x; ay2 = q.a_end_y;
    bx1 = q.b_start_x; by1 = q.b_start_y; bx2 = q.b_end_x; by2 = q.b_end_y;
    if (!(ax1 == ax2 && ay1 == ay2) && !(bx1 == bx2 && by1 == by2))
      hit = straddles(cross_of(bx1, by1, bx2, by2, ax1, ay1),
                      cross_of(bx1, by1, bx2, by2, ax2, ay2)) &&
            straddles(cross_of(ax1, ay1, ax2, ay2, bx1, by1),
                      cross_of(ax1, ay1, ax2, ay2, bx2, by2));
    if (hit) begin
      r.gap_length = '0;
      r.crossing = 1'b1;
      return r;
    end
    best = point_seg_sq(ax1, ay1, bx1, by1, bx2, by2);
    d = point_seg_sq(ax2, ay2, bx1, by1, bx2, by2); if (d < best) best = d;
    d = point_seg_sq(bx1, by1, ax1, ay1, ax2, ay2); if (d < best) best = d;
    d = point_seg_sq(bx2, by2, ax1, ay1, ax2, ay2); if (d < best) best = d;
    r.gap_length = 17'(floor_root(best));
    r.crossing = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000 + 16'($urandom_range(0, 3));
      1: return 16'h7fff - 16'($urandom_range(0, 3));
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_req_t make_pair(int kind);
    in_req_t q;
    logic signed [15:0] ox, oy, sx, sy;
    q = in_req_t'({$urandom, $urandom, $urandom, $urandom});
    case (kind)
      0: begin  // zero-length segment
        q.a_start_x = rand_coord(); q.a_start_y = rand_coord();
        if ($urandom_range(0, 1)) begin q.a_end_x = q.a_start_x; q.a_end_y = q.a_start_y; end
        else begin q.b_end_x = q.b_start_x; q.b_end_y = q.b_start_y; end
      end
      1: begin  // collinear, maybe disjoint
        ox = 16'(int'($urandom_range(0, 2000)) - 1000);
        oy = 16'(int'($urandom_range(0, 2000)) - 1000);
        sx = 16'(int'($urandom_range(0, 40)) - 20);
        sy = 16'(int'($urandom_range(0, 40)) - 20);
        q.a_start_x = ox;               q.a_start_y = oy;
        q.a_end_x = ox + sx;            q.a_end_y = oy + sy;
        q.b_start_x = 16'(ox + 3 * sx); q.b_start_y = 16'(oy + 3 * sy);
        q.b_end_x = 16'(ox + 5 * sx);   q.b_end_y = 16'(oy + 5 * sy);
      end
      2: begin  // touching at a shared endpoint
        q.b_start_x = q.a_end_x; q.b_start_y = q.a_end_y;
      end
      3: begin
        q.a_start_x = rand_coord(); q.a_start_y = rand_coord();
        q.a_end_x = rand_coord();   q.a_end_y = rand_coord();
        q.b_start_x = rand_coord(); q.b_start_y = rand_coord();
        q.b_end_x = rand_coord();   q.b_end_y = rand_coord();
      end
      default: ;
    endcase
    return q;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
    end else if (!req_valid_i || req_ready_o) begin
      if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
        req_i <= pending_q[0];
        expected_q.push_back(predict_gap(pending_q[0]));
        void'(pending_q.pop_front());
        req_valid_i <= 1'b1;
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp_o);
      end else begin
        if (rsp_o.gap_length !== expected_q[0].gap_length ||
            rsp_o.crossing !== expected_q[0].crossing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected gap %0d crossing %0b, got gap %0d crossing %0b",
                     expected_q[0].gap_length, expected_q[0].crossing,
                     rsp_o.gap_length, rsp_o.crossing);
        end
        void'(expected_q.pop_front());
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_ready_i <= 1'b0;
    end else if (hold_cnt == 300) begin
      hold_off <= 150;  // long stall so the pipe fills and backs up
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= calm || $urandom_range(0, 99) >= 34;
    end
    hold_cnt <= hold_cnt + 1;
  end

  initial begin
    in_req_t q;
    logic [15:0] ext[4];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    for (int i = 0; i < 8; i++) begin
      q = in_req_t'({8{ext[i % 4]}});
      q.b_end_x = ext[(i + 1) % 4];
      q.a_end_y = ext[(i + 2) % 4];
      pending_q.push_back(q);
    end
    pending_q.push_back(in_req_t'({16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                                    16'h8000, 16'h7fff, 16'h7fff, 16'h8000}));
    pending_q.push_back(in_req_t'({16'h8000, 16'h8000, 16'h8000, 16'h7fff,
                                    16'h7fff, 16'h8000, 16'h7fff, 16'h7fff}));
    pending_q.push_back(in_req_t'({16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                    16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}));
    for (int i = 0; i < 12; i++) pending_q.push_back(make_pair(i % 3));
    for (int i = 0; i < 650; i++) pending_q.push_back(make_pair($urandom_range(0, 5)));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() < 400);
    calm = 1'b1;
    wait (pending_q.size() < 250);
    calm = 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (req_valid_i && !req_ready_o) @(posedge clk_i);
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> segment_segment_distance_core.f
sv/ssd_pkg.sv
sv/ssd_front.sv
sv/ssd_div.sv
sv/ssd_dist.sv
sv/ssd_sqrt.sv
sv/segment_segment_distance_core.sv
sim/tb_top.sv
